// ===== rtl/ptcs_pkg.sv =====
`default_nettype none
package ptcs_pkg;

  localparam int unsigned SLOTS     = 5;
  localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SLOT_FLD_W = 3;
  localparam int unsigned DIV_CNT_W = $clog2(PERIOD_W + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_REGISTER   = 2'd1,
    CMD_DEREGISTER = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [ID_W-1:0]     client_id;
    logic [PERIOD_W-1:0] period;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]       client_id_res;
    logic [SLOT_FLD_W-1:0] slot;
    logic [PERIOD_W-1:0]   tick_count;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PERIOD_W-1:0] period;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] addr;
    entry_t            wdata;
  } mem_req_t;

  typedef struct packed {
    logic                start;
    logic [PERIOD_W-1:0] dividend;
    logic [PERIOD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/ptcs_slot_mem.sv =====
`default_nettype none
module ptcs_slot_mem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptcs_pkg::mem_req_t req_i,
  output ptcs_pkg::entry_t        rdata_o
);
  import ptcs_pkg::*;

  entry_t           mem_q [SLOTS];
  logic [SLOTS-1:0] valid_q;
  entry_t           rd_q;
  logic             rd_valid_q;

  // entries never written read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/ptcs_rem_div.sv =====
`default_nettype none
module ptcs_rem_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptcs_pkg::div_req_t req_i,
  output ptcs_pkg::div_rsp_t      rsp_o
);
  import ptcs_pkg::*;

  logic [PERIOD_W-1:0]  rem_q;
  logic [PERIOD_W-1:0]  num_q;
  logic [PERIOD_W-1:0]  den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W:0]    diff;
  logic [PERIOD_W-1:0]  rem_d;

  // restoring division, one quotient bit a cycle; only the remainder is kept
  always_comb begin
    trial = {rem_q, num_q[PERIOD_W-1]};
    diff  = trial - {1'b0, den_q};
    rem_d = (trial >= {1'b0, den_q}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(PERIOD_W);
    end else if (run_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[PERIOD_W-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/ptcs_ctrl.sv =====
`default_nettype none
module ptcs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire ptcs_pkg::in_t      item_i,
  output logic                    busy,
  output ptcs_pkg::mem_req_t      mem_req_o,
  input  wire ptcs_pkg::entry_t   mem_rdata_i,
  output ptcs_pkg::div_req_t      div_req_o,
  input  wire ptcs_pkg::div_rsp_t div_rsp_i,
  output logic                    res_strobe_o,
  output ptcs_pkg::out_t          result_o
);
  import ptcs_pkg::*;

  state_e              state_q, state_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  in_t                 item_q;
  logic [PERIOD_W-1:0] tick_q, tick_d;
  logic                pend_valid_q, pend_valid_d;
  logic [ID_W-1:0]     pend_id_q;
  logic [SLOT_W-1:0]   pend_slot_q;
  logic [ID_W-1:0]     cand_id_q;
  logic                res_strobe_q;
  out_t                res_q;

  logic                capture;
  logic                cand_load;
  logic                pend_load;
  logic                emit_en;
  logic                emit_last;
  logic                last_slot;
  logic                cmd_ok;

  assign last_slot = (idx_q == SLOT_W'(SLOTS - 1));
  assign busy      = (state_q != ST_IDLE);

  always_comb begin
    case (item_i.command)
      CMD_TICK:                     cmd_ok = 1'b1;
      CMD_REGISTER, CMD_DEREGISTER: cmd_ok = (item_i.client_id != '0);
      default:                      cmd_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_d            = state_q;
    idx_d              = idx_q;
    tick_d             = tick_q;
    pend_valid_d       = pend_valid_q;
    capture            = 1'b0;
    cand_load          = 1'b0;
    pend_load          = 1'b0;
    emit_en            = 1'b0;
    emit_last          = 1'b0;
    mem_req_o          = '0;
    mem_req_o.addr     = idx_q;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = tick_q;
    div_req_o.divisor  = mem_rdata_i.period;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          capture = 1'b1;
          idx_d   = '0;
          if (cmd_ok) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_req_o.rd_en = 1'b1;
        state_d         = ST_CHECK;
      end
      ST_CHECK: begin
        // read data for idx_q is ready; default is to move on
        if (last_slot) begin
          state_d = (item_q.command == CMD_TICK) ? ST_FIN : ST_IDLE;
        end else begin
          idx_d   = idx_q + SLOT_W'(1);
          state_d = ST_READ;
        end
        case (item_q.command)
          CMD_REGISTER: begin
            if (mem_rdata_i.id == '0) begin
              mem_req_o.wr_en        = 1'b1;
              mem_req_o.wdata.id     = item_q.client_id;
              mem_req_o.wdata.period = item_q.period;
              state_d                = ST_IDLE;
            end
          end
          CMD_DEREGISTER: begin
            if (mem_rdata_i.id == item_q.client_id) begin
              mem_req_o.wr_en = 1'b1;
              state_d         = ST_IDLE;
            end
          end
          default: begin
            if (mem_rdata_i.id != '0 && mem_rdata_i.period != '0) begin
              div_req_o.start = 1'b1;
              cand_load       = 1'b1;
              idx_d           = idx_q;
              state_d         = ST_DIV;
            end
          end
        endcase
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.rem == '0) begin
            // previous hit is now known not to be the last one
            emit_en      = pend_valid_q;
            pend_load    = 1'b1;
            pend_valid_d = 1'b1;
          end
          if (last_slot) begin
            state_d = ST_FIN;
          end else begin
            idx_d   = idx_q + SLOT_W'(1);
            state_d = ST_READ;
          end
        end
      end
      ST_FIN: begin
        emit_en      = pend_valid_q;
        emit_last    = 1'b1;
        pend_valid_d = 1'b0;
        tick_d       = tick_q + PERIOD_W'(1);
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      tick_q       <= '0;
      pend_valid_q <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      tick_q       <= tick_d;
      pend_valid_q <= pend_valid_d;
      res_strobe_q <= emit_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      item_q <= item_i;
    end
    if (cand_load) begin
      cand_id_q <= mem_rdata_i.id;
    end
    if (pend_load) begin
      pend_id_q   <= cand_id_q;
      pend_slot_q <= idx_q;
    end
    if (emit_en) begin
      res_q.client_id_res <= pend_id_q;
      res_q.slot          <= SLOT_FLD_W'(pend_slot_q);
      res_q.tick_count    <= tick_q;
      res_q.last          <= emit_last;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign result_o     = res_q;

endmodule
`default_nettype wire

// ===== rtl/periodic_tick_client_scheduler_unit.sv =====
`default_nettype none
// Periodic tick scheduler for up to five clients. Words are taken when start is high and busy
// is low; register and deregister scan the slot memory for the first free or matching slot,
// a tick reads each slot in turn and runs a bit-serial remainder unit on occupied slots with
// a nonzero period, then closes, with the final word out in the cycle after the close.
// Results leave on res_strobe_o, one cycle each, in slot order while the scan runs, the final
// one flagged by last; they cannot be held off, so the receiver must take every strobe.
// Invalid commands, and register or deregister words with id zero, are dropped without
// raising busy.
module periodic_tick_client_scheduler_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire ptcs_pkg::in_t  item_i,
  output logic                busy,
  output logic                res_strobe_o,
  output ptcs_pkg::out_t      result_o
);
  import ptcs_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  ptcs_slot_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  ptcs_rem_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ptcs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .item_i       (item_i),
    .busy         (busy),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .res_strobe_o (res_strobe_o),
    .result_o     (result_o)
  );

  a_fire_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> result_o.client_id_res != '0)
    else $error("result word with empty client id");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !result_o.last |-> busy)
    else $error("non-final result word outside a tick scan");

  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.rd_en && mem_req.wr_en) && (!mem_req.wr_en || busy))
    else $error("slot memory access overlap or write while idle");

  a_div_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> busy)
    else $error("remainder unit finished outside a tick scan");

endmodule
`default_nettype wire
